// ===== src/qpls_pkg.sv =====
// Shared types and constants for the quantized paired-single convert block.
// No dependencies; used by every module in src.
`default_nettype none
package qpls_pkg;

   localparam logic [2:0] KIND_U8  = 3'd4;
   localparam logic [2:0] KIND_U16 = 3'd5;
   localparam logic [2:0] KIND_S8  = 3'd6;
   localparam logic [2:0] KIND_S16 = 3'd7;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_STORE = 1'b1;

   localparam logic [63:0] ONE_BITS = 64'h3ff0000000000000;

   typedef struct packed {
      logic        action;
      logic [31:0] quant_word;
      logic        single_flag;
      logic [63:0] value_first;
      logic [63:0] value_second;
   } req_type;

   typedef struct packed {
      logic [63:0] result_first;
      logic [63:0] result_second;
      logic [2:0]  element_size;
      logic        second_used;
   } rsp_type;

   // decoded quantization control shared by both lanes
   typedef struct packed {
      logic              action;
      logic [2:0]        kind;
      logic signed [5:0] scale;
   } lane_ctrl_type;

endpackage
`default_nettype wire

// ===== src/qpls_lane.sv =====
// One conversion lane: dequantize (load) or quantize (store) a single element.
// Depends on qpls_pkg.
`default_nettype none
module qpls_lane (
   input  wire qpls_pkg::lane_ctrl_type ctrl,
   input  wire logic [63:0]             value,
   output logic [63:0]                  result
);

   // load, float kinds: single -> double
   logic [7:0]  ld_ex;
   logic [22:0] ld_fr;
   logic [4:0]  ld_k;
   logic [51:0] ld_dmant;
   logic [10:0] ld_e;
   logic [63:0] ld_float;

   // load, integer kinds
   logic        li_neg;
   logic [15:0] li_mag;
   logic [3:0]  li_p;
   logic [51:0] li_mant;
   logic [10:0] li_e;
   logic [63:0] ld_int;

   // store, float kinds: double -> single
   logic        st_sign;
   logic [10:0] st_ex;
   logic [51:0] st_fr;
   logic [52:0] st_m;
   logic [5:0]  st_sh;
   logic [31:0] st_float;

   // store, integer kinds
   logic signed [12:0] st_e;
   logic signed [17:0] st_lo;
   logic signed [17:0] st_hi;
   logic [52:0]        st_shifted;
   logic [16:0]        st_int;
   logic signed [17:0] st_sv;
   logic signed [17:0] st_r;
   logic [31:0]        st_word;

   always_comb begin
      ld_ex = value[30:23];
      ld_fr = value[22:0];
      ld_k  = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (ld_fr[i]) ld_k = 5'(i);
      end
      ld_dmant = {ld_fr, 29'd0} << (5'd23 - ld_k);
      ld_e     = (ld_ex == 8'hff) ? 11'h7ff : ({3'd0, ld_ex} + 11'd896);
      if (ld_ex != 8'd0) begin
         ld_float = {value[31], ld_e, ld_fr, 29'd0};
      end else if (ld_fr == 23'd0) begin
         ld_float = {value[31], 63'd0};
      end else begin
         ld_float = {value[31], 11'd874 + {6'd0, ld_k}, ld_dmant};
      end
   end

   always_comb begin
      case (ctrl.kind)
         qpls_pkg::KIND_U8: begin
            li_neg = 1'b0;
            li_mag = {8'd0, value[7:0]};
         end
         qpls_pkg::KIND_U16: begin
            li_neg = 1'b0;
            li_mag = value[15:0];
         end
         qpls_pkg::KIND_S8: begin
            li_neg = value[7];
            li_mag = value[7] ? {8'd0, 8'(~value[7:0] + 8'd1)} : {8'd0, value[7:0]};
            if (value[7:0] == 8'h80) li_mag = 16'd128;
         end
         default: begin
            li_neg = value[15];
            li_mag = value[15] ? 16'(~value[15:0] + 16'd1) : value[15:0];
         end
      endcase
      li_p = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (li_mag[i]) li_p = 4'(i);
      end
      li_mant = {li_mag, 36'd0} << (5'd16 - {1'b0, li_p});
      li_e    = 11'd1023 + {7'd0, li_p} - 11'(signed'(ctrl.scale));
      ld_int  = (li_mag == 16'd0) ? 64'd0 : {li_neg, li_e, li_mant};
   end

   always_comb begin
      st_sign = value[63];
      st_ex   = value[62:52];
      st_fr   = value[51:0];
      st_m    = {1'b1, st_fr};
      st_sh   = 6'(11'd926 - st_ex);
      if (st_ex > 11'd896 || value[62:0] == 63'd0) begin
         st_float = {st_sign, st_ex[10], st_ex[6:0], st_fr[51:29]};
      end else if (st_ex >= 11'd874) begin
         st_float = {st_sign, 8'd0, 23'(st_m >> st_sh)};
      end else begin
         st_float = {st_sign, 31'd0};
      end
   end

   always_comb begin
      case (ctrl.kind)
         qpls_pkg::KIND_U8: begin
            st_lo = 18'sd0;
            st_hi = 18'sd255;
         end
         qpls_pkg::KIND_U16: begin
            st_lo = 18'sd0;
            st_hi = 18'sd65535;
         end
         qpls_pkg::KIND_S8: begin
            st_lo = -18'sd128;
            st_hi = 18'sd127;
         end
         default: begin
            st_lo = -18'sd32768;
            st_hi = 18'sd32767;
         end
      endcase
      st_e       = $signed({2'b00, st_ex}) - 13'sd1023 + 13'(signed'(ctrl.scale));
      st_shifted = st_m >> (6'd52 - {2'b00, st_e[3:0]});
      st_int     = st_shifted[16:0];
      st_sv      = st_sign ? -$signed({1'b0, st_int}) : $signed({1'b0, st_int});
      if (st_ex == 11'h7ff && st_fr != 52'd0) begin
         st_r = st_hi;                       // NaN saturates high
      end else if (st_e >= 13'sd16) begin
         st_r = st_sign ? st_lo : st_hi;     // overflow or infinity
      end else if (st_e < 13'sd0) begin
         st_r = 18'sd0;
      end else if (st_sv > st_hi) begin
         st_r = st_hi;
      end else if (st_sv < st_lo) begin
         st_r = st_lo;
      end else begin
         st_r = st_sv;
      end
      st_word = 32'(st_r);
   end

   always_comb begin
      if (ctrl.action == qpls_pkg::ACT_STORE) begin
         result = {32'd0, ctrl.kind[2] ? st_word : st_float};
      end else begin
         result = ctrl.kind[2] ? ld_int : ld_float;
      end
   end

endmodule
`default_nettype wire

// ===== src/qpls_merge.sv =====
// Merge stage: combines both lane results, applies the single flag and
// element size, and holds the response register. Depends on qpls_pkg.
`default_nettype none
module qpls_merge (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    take,
   input  wire qpls_pkg::lane_ctrl_type ctrl,
   input  wire logic                    single_flag,
   input  wire logic [63:0]             lane0_result,
   input  wire logic [63:0]             lane1_result,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output qpls_pkg::rsp_type            rsp_payload,
   output logic                         free
);

   logic              valid_ff, valid_in;
   qpls_pkg::rsp_type data_ff, data_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      data_in.result_first = lane0_result;
      if (!single_flag) begin
         data_in.result_second = lane1_result;
      end else if (ctrl.action == qpls_pkg::ACT_STORE) begin
         data_in.result_second = 64'd0;
      end else begin
         data_in.result_second = qpls_pkg::ONE_BITS;
      end
      case (ctrl.kind) inside
         qpls_pkg::KIND_U8, qpls_pkg::KIND_S8:   data_in.element_size = 3'd1;
         qpls_pkg::KIND_U16, qpls_pkg::KIND_S16: data_in.element_size = 3'd2;
         default:                                data_in.element_size = 3'd4;
      endcase
      data_in.second_used = !single_flag;
      valid_in = take ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
   a_size_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.element_size == 3'd1 || rsp_payload.element_size == 3'd2
                     || rsp_payload.element_size == 3'd4))
      else $error("bad element size");
   a_single_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.second_used) |->
      (rsp_payload.result_second == 64'd0 || rsp_payload.result_second == qpls_pkg::ONE_BITS))
      else $error("second result not suppressed");
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("accepted transaction lost");

endmodule
`default_nettype wire

// ===== src/quantized_pair_load_store_convert.sv =====
// Quantized paired-single load/store converter, two lanes plus merge register.
// Response is valid in the cycle after acceptance. Throughput: one transaction
// per cycle while rsp_ready is high; the response register frees in the
// same cycle it is drained, so back-to-back requests never bubble.
// Reset (synchronous, active high) empties the response register only.
// Depends on qpls_pkg, qpls_lane, qpls_merge.
`default_nettype none
module quantized_pair_load_store_convert (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire qpls_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output qpls_pkg::rsp_type      rsp_payload
);

   qpls_pkg::lane_ctrl_type ctrl;
   logic [63:0]             lane0_result;
   logic [63:0]             lane1_result;
   logic                    free;
   logic                    take;

   // load takes type/scale from the upper half, store from the lower half
   always_comb begin
      ctrl.action = req_payload.action;
      if (req_payload.action == qpls_pkg::ACT_STORE) begin
         ctrl.kind  = req_payload.quant_word[2:0];
         ctrl.scale = req_payload.quant_word[13:8];
      end else begin
         ctrl.kind  = req_payload.quant_word[18:16];
         ctrl.scale = req_payload.quant_word[29:24];
      end
   end

   assign req_ready = free;
   assign take      = req_valid && free;

   // lane 0: first element, lane 1: second element
   qpls_lane u_lane0 (
      .ctrl   (ctrl),
      .value  (req_payload.value_first),
      .result (lane0_result)
   );

   qpls_lane u_lane1 (
      .ctrl   (ctrl),
      .value  (req_payload.value_second),
      .result (lane1_result)
   );

   qpls_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .ctrl         (ctrl),
      .single_flag  (req_payload.single_flag),
      .lane0_result (lane0_result),
      .lane1_result (lane1_result),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .free         (free)
   );

endmodule
`default_nettype wire

// ===== dv/qpls_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for quantized_pair_load_store_convert: predicts each response from
// the accepted request and compares it field by field. Depends on qpls_pkg.
module qpls_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire qpls_pkg::req_type req_payload,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire qpls_pkg::rsp_type rsp_payload,
   output int   mismatch_count,
   output int   outstanding,
   output int   load_count,
   output int   store_count
);

   qpls_pkg::rsp_type expected_rsps[$];
   int                errors;

   function automatic real pow2(input int s);
      logic [63:0] b;
      b = 64'(1023 + s) << 52;
      return $bitstoreal(b);
   endfunction

   function automatic logic [63:0] single_to_double(input logic [31:0] w);
      logic [7:0]  ex;
      logic [22:0] fr;
      logic [10:0] e;
      int          k;
      ex = w[30:23];
      fr = w[22:0];
      if (ex != 8'd0) begin
         e = (ex == 8'hff) ? 11'h7ff : 11'(ex) + 11'd896;
         return {w[31], e, fr, 29'd0};
      end
      if (fr == 23'd0) return {w[31], 63'd0};
      k = 22;
      while (k > 0 && fr[k] == 1'b0) k--;
      return {w[31], 11'(k + 874), 52'((64'(fr) - (64'd1 << k)) << (52 - k))};
   endfunction

   function automatic logic [31:0] double_to_single(input logic [63:0] b);
      logic [10:0] ex;
      logic [52:0] m;
      logic [52:0] sh;
      ex = b[62:52];
      if (ex > 11'd896 || b[62:0] == 63'd0)
         return {b[63], ex[10], ex[6:0], b[51:29]};
      if (ex >= 11'd874) begin
         m  = {1'b1, b[51:0]};
         sh = m >> (926 - int'(ex));
         return {b[63], 8'd0, sh[22:0]};
      end
      return {b[63], 31'd0};
   endfunction

   function automatic logic [63:0] dequantize(input logic [63:0] raw, input logic [2:0] kind,
                                              input logic signed [5:0] scale);
      int v;
      if (kind < qpls_pkg::KIND_U8) return single_to_double(raw[31:0]);
      case (kind)
         qpls_pkg::KIND_U8:  v = int'(raw[7:0]);
         qpls_pkg::KIND_U16: v = int'(raw[15:0]);
         qpls_pkg::KIND_S8:  v = int'($signed(raw[7:0]));
         default:            v = int'($signed(raw[15:0]));
      endcase
      return $realtobits(real'(v) * pow2(-int'(scale)));
   endfunction

   function automatic logic [63:0] quantize(input logic [63:0] bits, input logic [2:0] kind,
                                            input logic signed [5:0] scale);
      int  lo, hi, r;
      real v;
      logic is_nan;
      if (kind < qpls_pkg::KIND_U8) return {32'd0, double_to_single(bits)};
      case (kind)
         qpls_pkg::KIND_U8:  begin lo = 0;      hi = 255;   end
         qpls_pkg::KIND_U16: begin lo = 0;      hi = 65535; end
         qpls_pkg::KIND_S8:  begin lo = -128;   hi = 127;   end
         default:            begin lo = -32768; hi = 32767; end
      endcase
      is_nan = (bits[62:52] == 11'h7ff) && (bits[51:0] != 52'd0);
      v = $bitstoreal(bits) * pow2(int'(scale));
      if (is_nan || v > real'(hi)) r = hi;
      else if (v < real'(lo)) r = lo;
      else r = $rtoi(v);
      return {32'd0, 32'(r)};
   endfunction

   function automatic qpls_pkg::rsp_type convert_pair(input qpls_pkg::req_type t);
      qpls_pkg::rsp_type o;
      logic [2:0]        kind;
      logic signed [5:0] scale;
      if (t.action == qpls_pkg::ACT_LOAD) begin
         kind  = t.quant_word[18:16];
         scale = t.quant_word[29:24];
         o.result_first  = dequantize(t.value_first, kind, scale);
         o.result_second = t.single_flag ? qpls_pkg::ONE_BITS
                                         : dequantize(t.value_second, kind, scale);
      end else begin
         kind  = t.quant_word[2:0];
         scale = t.quant_word[13:8];
         o.result_first  = quantize(t.value_first, kind, scale);
         o.result_second = t.single_flag ? 64'd0 : quantize(t.value_second, kind, scale);
      end
      o.element_size = (kind == qpls_pkg::KIND_U8 || kind == qpls_pkg::KIND_S8) ? 3'd1 :
                       (kind == qpls_pkg::KIND_U16 || kind == qpls_pkg::KIND_S16) ? 3'd2 :
                       3'd4;
      o.second_used  = !t.single_flag;
      return o;
   endfunction

   always @(posedge clock) begin
      qpls_pkg::rsp_type want;
      if (reset) begin
         expected_rsps.delete();
         errors = 0;
         load_count  <= 0;
         store_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_payload);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.result_first !== want.result_first) begin
                  $display("%0t: result_first exp %h got %h", $time,
                           want.result_first, rsp_payload.result_first);
                  errors++;
               end
               if (rsp_payload.result_second !== want.result_second) begin
                  $display("%0t: result_second exp %h got %h", $time,
                           want.result_second, rsp_payload.result_second);
                  errors++;
               end
               if (rsp_payload.element_size !== want.element_size) begin
                  $display("%0t: element_size exp %0d got %0d", $time,
                           want.element_size, rsp_payload.element_size);
                  errors++;
               end
               if (rsp_payload.second_used !== want.second_used) begin
                  $display("%0t: second_used exp %0d got %0d", $time,
                           want.second_used, rsp_payload.second_used);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(convert_pair(req_payload));
            if (req_payload.action == qpls_pkg::ACT_LOAD) load_count <= load_count + 1;
            else store_count <= store_count + 1;
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_rsps.size();
   end

endmodule

// ===== dv/quantized_pair_load_store_convert_test.sv =====
`timescale 1ns / 1ps
// Testbench top for quantized_pair_load_store_convert: drives load/store
// transactions and gives the verdict. Depends on qpls_pkg, qpls_checker and the DUT.
module quantized_pair_load_store_convert_test;

   localparam int RANDOM_ITEMS = 1830;
   localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side
   localparam int STALL_CYCLES = 300;   // long receiver hold-off

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   qpls_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   qpls_pkg::rsp_type rsp_payload;

   int mismatch_count, outstanding, load_count, store_count;
   int idle_cycles;
   logic stall_request;  // sender asks the receiver for one long hold-off

   quantized_pair_load_store_convert u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   qpls_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .mismatch_count(mismatch_count), .outstanding(outstanding),
      .load_count(load_count), .store_count(store_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Gap length: mostly zero or short, occasionally long.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // Build a transaction; unused quant_word bits stay random.
   function automatic qpls_pkg::req_type make_txn(input logic act, input logic [2:0] kind,
                                                  input logic [5:0] scale, input logic single,
                                                  input logic [63:0] a, input logic [63:0] b);
      qpls_pkg::req_type t;
      t.action       = act;
      t.quant_word   = $urandom;
      if (act == qpls_pkg::ACT_LOAD) begin
         t.quant_word[18:16] = kind;
         t.quant_word[29:24] = scale;
      end else begin
         t.quant_word[2:0]  = kind;
         t.quant_word[13:8] = scale;
      end
      t.single_flag  = single;
      t.value_first  = a;
      t.value_second = b;
      return t;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Store operands: mostly moderate magnitudes so the integer kinds do not just clamp,
   // plus the single denormal band, specials and raw noise.
   function automatic logic [63:0] store_operand();
      logic [63:0] v;
      v = rand64();
      case ($urandom_range(0, 9)) inside
         0, 1:    ;
         2:       v[62:52] = 11'($urandom_range(860, 900));
         3:       v[62:52] = 11'h7ff;
         4:       v[62:0]  = 63'd0;
         default: v[62:52] = 11'($urandom_range(1023 - 40, 1023 + 20));
      endcase
      return v;
   endfunction

   task automatic send(input qpls_pkg::req_type t);
      int g;
      req_payload <= t;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0 || rsp_valid) @(posedge clock);
   endtask

   // Receiver: random back-pressure with runs of full throughput, one long hold-off.
   initial begin
      int hold;
      int run;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (stall_request) begin
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            stall_request = 1'b0;
         end
         if ($urandom_range(0, 3) == 0) begin
            run = $urandom_range(5, 30);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
         end else begin
            hold = gap_len();
            if (hold > 0) begin
               rsp_ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog: ends the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL quantized_pair_load_store_convert");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] qnan, pinf, ninf;
      logic        act;
      logic [2:0]  kind;
      qnan = 64'h7ff8_0000_0000_0001;
      pinf = 64'h7ff0_0000_0000_0000;
      ninf = 64'hfff0_0000_0000_0000;
      stall_request = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every kind both ways, bounds of raw elements and scales.
      send(make_txn(qpls_pkg::ACT_LOAD, 3'd0, 6'd0, 1'b0,
                    64'h0000_0000_0000_0001, 64'h8000_0000_8040_0000));
      send(make_txn(qpls_pkg::ACT_LOAD, 3'd1, 6'd0, 1'b0,
                    64'hffff_ffff_7f80_0000, 64'h7fc0_0001));
      send(make_txn(qpls_pkg::ACT_LOAD, 3'd2, 6'd5, 1'b1,
                    64'h3f80_0000, 64'hffff_ffff_ffff_ffff));
      send(make_txn(qpls_pkg::ACT_LOAD, 3'd3, 6'd0, 1'b0, 64'h8000_0000, 64'h007f_ffff));
      send(make_txn(qpls_pkg::ACT_LOAD, qpls_pkg::KIND_U8, 6'h20, 1'b0,
                    64'hffff_ffff_ffff_ffff, 64'h0));
      send(make_txn(qpls_pkg::ACT_LOAD, qpls_pkg::KIND_U16, 6'h1f, 1'b0,
                    64'hffff_ffff_ffff_ffff, 64'h8000));
      send(make_txn(qpls_pkg::ACT_LOAD, qpls_pkg::KIND_S8, 6'h20, 1'b1, 64'h80, 64'h7f));
      send(make_txn(qpls_pkg::ACT_LOAD, qpls_pkg::KIND_S16, 6'h1f, 1'b0,
                    64'h8000, 64'hffff_ffff_ffff_7fff));
      send(make_txn(qpls_pkg::ACT_STORE, 3'd0, 6'd0, 1'b0,
                    64'h3810_0000_0000_0000, 64'h36a0_0000_0000_0001));
      send(make_txn(qpls_pkg::ACT_STORE, 3'd1, 6'd0, 1'b0,
                    64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001));
      send(make_txn(qpls_pkg::ACT_STORE, 3'd2, 6'd0, 1'b1, qnan, ninf));
      send(make_txn(qpls_pkg::ACT_STORE, 3'd3, 6'd0, 1'b0,
                    64'hffff_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000));
      send(make_txn(qpls_pkg::ACT_STORE, qpls_pkg::KIND_U8, 6'h1f, 1'b0, qnan, pinf));
      send(make_txn(qpls_pkg::ACT_STORE, qpls_pkg::KIND_U8, 6'h20, 1'b0,
                    ninf, 64'h406f_e000_0000_0000));
      send(make_txn(qpls_pkg::ACT_STORE, qpls_pkg::KIND_U16, 6'd0, 1'b1,
                    64'h40ef_ffe0_0000_0000, 64'h0));
      send(make_txn(qpls_pkg::ACT_STORE, qpls_pkg::KIND_S8, 6'd0, 1'b0,
                    64'hc060_2000_0000_0000, 64'h405f_c000_0000_0000));
      send(make_txn(qpls_pkg::ACT_STORE, qpls_pkg::KIND_S8, 6'h3f, 1'b0,
                    64'hbfff_ffff_ffff_ffff, 64'h8000_0000_0000_0000));
      send(make_txn(qpls_pkg::ACT_STORE, qpls_pkg::KIND_S16, 6'd0, 1'b0,
                    64'hc0e0_0020_0000_0000, qnan));
      send(make_txn(qpls_pkg::ACT_STORE, qpls_pkg::KIND_S16, 6'h1f, 1'b0,
                    pinf, 64'h0000_0000_0000_0001));
      send(make_txn(qpls_pkg::ACT_STORE, qpls_pkg::KIND_S16, 6'h20, 1'b1,
                    64'hc0df_ffc0_0000_0000, ninf));

      // Random: raw loads, shaped store operands, full-range quant words.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400) stall_request = 1'b1;  // sender keeps offering meanwhile
         if (i == 1000) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         act  = logic'($urandom_range(0, 1));
         kind = 3'($urandom_range(0, 7));
         if (act == qpls_pkg::ACT_LOAD)
            send(make_txn(act, kind, 6'($urandom), logic'($urandom_range(0, 1)),
                          rand64(), rand64()));
         else
            send(make_txn(act, kind, $urandom_range(0, 3) == 0 ? 6'($urandom)
                                                               : 6'($urandom_range(0, 8)),
                          logic'($urandom_range(0, 1)), store_operand(), store_operand()));
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Covered %0d loads and %0d stores over all eight kinds, both pair modes,",
               load_count, store_count);
      $display("random back-pressure, one long response stall and one full drain.");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASS quantized_pair_load_store_convert");
      end else begin
         $display("FAIL quantized_pair_load_store_convert");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/qpls_pkg.sv
src/qpls_lane.sv
src/qpls_merge.sv
src/quantized_pair_load_store_convert.sv
dv/qpls_checker.sv
dv/quantized_pair_load_store_convert_test.sv
